### sv/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants for the CR LF line command tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Configuration register width and its reset value
  localparam int CFG_W                   = 16;
  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 16'd5120;

  // Defaults for the top level parameters
  localparam int TOKEN_INDEX_MAX_DEFAULT = 63;
  localparam int LENGTH_WIDTH_DEFAULT    = 16;
  localparam int FIFO_DEPTH_DEFAULT      = 4;

  // Result kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_END      = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_TOO_LONG = 2'd3;

  // Input actions
  localparam logic ACT_DATA    = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;

  // One result
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_byte;
    logic [5:0] token_index;
    logic       is_trailing;
    logic       last;
  } result_t;

  // All results caused by one input byte (one or two)
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } record_t;

  // Handshake between the queue and the output stage
  typedef struct packed {
    logic pop;
  } qctl_t;

endpackage

### sv/clt_front.sv
// ----------------------------------------------------------------------------
// clt_front
// Accepts bytes, tracks line and word state, and builds the result record
// for each byte in the same cycle.
// ----------------------------------------------------------------------------
module clt_front #(
  parameter int TOKEN_INDEX_MAX = clt_pkg::TOKEN_INDEX_MAX_DEFAULT,
  parameter int LENGTH_WIDTH    = clt_pkg::LENGTH_WIDTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [clt_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_action,
  input  logic [7:0]                in_data_byte,
  input  logic                      q_full,
  output logic                      q_push,
  output clt_pkg::record_t          q_rec
);
  import clt_pkg::*;

  localparam int CW   = $clog2(TOKEN_INDEX_MAX + 1);
  localparam int CMPW = ((LENGTH_WIDTH > CFG_W) ? LENGTH_WIDTH : CFG_W) + 1;

  localparam logic [1:0] MODE_BETWEEN = 2'd0;
  localparam logic [1:0] MODE_WORD    = 2'd1;
  localparam logic [1:0] MODE_TRAIL   = 2'd2;

  logic [CFG_W-1:0]        max_len_r;
  logic [1:0]              mode_r, mode_nxt;
  logic                    after_sp_r, after_sp_nxt;
  logic                    cr_r, cr_nxt;
  logic                    name_r, name_nxt;
  logic                    tnz_r, tnz_nxt;
  logic [CW-1:0]           tc_r, tc_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;
  logic                    kick_r, kick_nxt;

  logic                    accept;
  logic [CMPW-1:0]         len_inc;
  logic                    is_sp;
  logic [1:0]              n_v;
  result_t                 res_v [2];

  // Build a result with the token index cut to the port width
  function automatic result_t mk(input logic [1:0] kind, input logic [7:0] b,
                                 input logic [CW-1:0] idx, input logic trail);
    logic [CW+5:0] wide;
    result_t       r;
    wide          = {6'd0, idx};
    r.kind        = kind;
    r.token_byte  = b;
    r.token_index = wide[5:0];
    r.is_trailing = trail;
    r.last        = 1'b0;
    return r;
  endfunction

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign len_inc = CMPW'(len_r) + 1'b1;
  assign is_sp   = ((in_data_byte >= CH_TAB) && (in_data_byte <= CH_CR)) ||
                   (in_data_byte == CH_SPACE);

  // Next state and results for the byte on the input
  always_comb begin
    mode_nxt     = mode_r;
    after_sp_nxt = after_sp_r;
    cr_nxt       = cr_r;
    name_nxt     = name_r;
    tnz_nxt      = tnz_r;
    tc_nxt       = tc_r;
    len_nxt      = len_r;
    kick_nxt     = kick_r;
    n_v          = 2'd0;
    res_v[0]     = '0;
    res_v[1]     = '0;
    if (accept) begin
      if (in_action == ACT_RESTART) begin
        kick_nxt     = 1'b0;
        mode_nxt     = MODE_BETWEEN;
        after_sp_nxt = 1'b0;
        cr_nxt       = 1'b0;
        name_nxt     = 1'b0;
        tnz_nxt      = 1'b0;
        tc_nxt       = '0;
        len_nxt      = '0;
      end else if (!kick_r) begin
        if (len_inc > CMPW'(max_len_r)) begin
          // Line too long: report once, then drop bytes
          kick_nxt = 1'b1;
          res_v[0] = mk(KIND_TOO_LONG, 8'd0, '0, 1'b0);
          n_v      = 2'd1;
        end else begin
          if (len_inc > CMPW'({LENGTH_WIDTH{1'b1}})) begin
            len_nxt = '1;
          end else begin
            len_nxt = len_inc[LENGTH_WIDTH-1:0];
          end
          if (cr_r && (in_data_byte == CH_LF)) begin
            // End of line
            if (name_r) begin
              if ((mode_r == MODE_TRAIL) && tnz_r) begin
                res_v[0] = mk(KIND_END, 8'd0, tc_nxt, 1'b1);
                n_v      = 2'd1;
                if (tc_nxt < CW'(TOKEN_INDEX_MAX)) begin
                  tc_nxt = tc_nxt + 1'b1;
                end
              end
              res_v[n_v[0]] = mk(KIND_COMPLETE, 8'd0, tc_nxt, 1'b0);
              n_v           = n_v + 2'd1;
            end
            mode_nxt     = MODE_BETWEEN;
            after_sp_nxt = 1'b0;
            cr_nxt       = 1'b0;
            name_nxt     = 1'b0;
            tnz_nxt      = 1'b0;
            tc_nxt       = '0;
            len_nxt      = '0;
          end else begin
            // Release a held CR inside the trailing parameter
            if (cr_r) begin
              cr_nxt = 1'b0;
              if ((mode_r == MODE_TRAIL) && name_r) begin
                res_v[0] = mk(KIND_BYTE, CH_CR, tc_r, 1'b1);
                n_v      = 2'd1;
                tnz_nxt  = 1'b1;
              end
            end
            if (mode_r == MODE_TRAIL) begin
              if (in_data_byte == CH_CR) begin
                cr_nxt = 1'b1;
              end else if (name_r) begin
                res_v[n_v[0]] = mk(KIND_BYTE, in_data_byte, tc_r, 1'b1);
                n_v           = n_v + 2'd1;
                tnz_nxt       = 1'b1;
              end
            end else begin
              if (in_data_byte == CH_CR) begin
                cr_nxt = 1'b1;
              end
              if (is_sp) begin
                if (mode_r == MODE_WORD) begin
                  res_v[n_v[0]] = mk(KIND_END, 8'd0, tc_r, 1'b0);
                  n_v           = n_v + 2'd1;
                  if (tc_r < CW'(TOKEN_INDEX_MAX)) begin
                    tc_nxt = tc_r + 1'b1;
                  end
                  mode_nxt = MODE_BETWEEN;
                end
                after_sp_nxt = (in_data_byte == CH_SPACE);
              end else if ((mode_r == MODE_BETWEEN) && after_sp_r &&
                           (in_data_byte == CH_COLON)) begin
                mode_nxt     = MODE_TRAIL;
                after_sp_nxt = 1'b0;
              end else begin
                after_sp_nxt  = 1'b0;
                mode_nxt      = MODE_WORD;
                name_nxt      = 1'b1;
                res_v[n_v[0]] = mk(KIND_BYTE, in_data_byte, tc_r, 1'b0);
                n_v           = n_v + 2'd1;
              end
            end
          end
        end
      end
    end
  end

  // Mark the final result and hand the record to the queue
  always_comb begin
    q_rec         = '0;
    q_rec.two     = (n_v == 2'd2);
    q_rec.r0      = res_v[0];
    q_rec.r1      = res_v[1];
    q_rec.r0.last = (n_v != 2'd2);
    q_rec.r1.last = 1'b1;
  end
  assign q_push = (n_v != 2'd0);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      max_len_r <= cfg_data;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_BETWEEN;
      after_sp_r <= 1'b0;
      cr_r       <= 1'b0;
      name_r     <= 1'b0;
      tnz_r      <= 1'b0;
      tc_r       <= '0;
      len_r      <= '0;
      kick_r     <= 1'b0;
    end else begin
      mode_r     <= mode_nxt;
      after_sp_r <= after_sp_nxt;
      cr_r       <= cr_nxt;
      name_r     <= name_nxt;
      tnz_r      <= tnz_nxt;
      tc_r       <= tc_nxt;
      len_r      <= len_nxt;
      kick_r     <= kick_nxt;
    end
  end

endmodule

### sv/clt_fifo.sv
// ----------------------------------------------------------------------------
// clt_fifo
// Short queue of result records between the parser and the output stage.
// ----------------------------------------------------------------------------
module clt_fifo #(
  parameter int FIFO_DEPTH = clt_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  clt_pkg::record_t push_rec,
  output logic             full,
  input  clt_pkg::qctl_t   ctl_in,
  output logic             empty,
  output clt_pkg::record_t head_rec
);
  import clt_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int NW = $clog2(FIFO_DEPTH + 1);

  record_t         mem [FIFO_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [NW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full     = (cnt_r == NW'(FIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = ctl_in.pop && !empty;
  assign head_rec = mem[rd_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Store records
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### sv/clt_back.sv
// ----------------------------------------------------------------------------
// clt_back
// Output stage: takes one record from the queue and presents its results
// one at a time on the result channel.
// ----------------------------------------------------------------------------
module clt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  clt_pkg::record_t q_head,
  output clt_pkg::qctl_t   q_ctl,
  output logic             out_empty,
  input  logic             out_pop,
  output clt_pkg::result_t out_res
);
  import clt_pkg::*;

  record_t rec_r, rec_nxt;
  logic    sel_r, sel_nxt;
  logic    vld_r, vld_nxt;
  logic    take, done, load;

  assign take = out_pop && vld_r;
  assign done = take && (sel_r || !rec_r.two);
  assign load = (!vld_r || done) && !q_empty;

  assign q_ctl.pop   = load;
  assign out_empty   = !vld_r;
  assign out_res     = sel_r ? rec_r.r1 : rec_r.r0;

  // Load next record, step to the second result, or drain
  always_comb begin
    rec_nxt = rec_r;
    sel_nxt = sel_r;
    vld_nxt = vld_r;
    if (load) begin
      rec_nxt = q_head;
      sel_nxt = 1'b0;
      vld_nxt = 1'b1;
    end else if (done) begin
      vld_nxt = 1'b0;
    end else if (take) begin
      sel_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sel_r <= sel_nxt;
    end
  end

endmodule

### sv/crlf_line_command_tokenizer.sv
// ----------------------------------------------------------------------------
// crlf_line_command_tokenizer
// Frames a byte stream on CR LF, splits lines into a command name and
// parameters, and reports token bytes, token ends and command completion.
// ----------------------------------------------------------------------------
//   Channel  Handshake          Payload
//   input    in_push / in_full  in_action, in_data_byte
//   result   out_pop / out_empty out_kind, out_token_byte, out_token_index,
//                               out_is_trailing, out_last
//   config   cfg_we             cfg_data (max_line_length)
//
// One byte is parsed per cycle while the queue has room; its one or two
// results enter the queue in the same cycle and leave on the result side
// one per cycle while out_pop is high, by way of the output register. The
// output stage sets the long run rate: one result per cycle.
// Reset is synchronous on rst_n low and loads max_line_length with 5120.
// A stalled result side fills the queue, which raises in_full.
// ----------------------------------------------------------------------------
module crlf_line_command_tokenizer #(
  parameter int TOKEN_INDEX_MAX = clt_pkg::TOKEN_INDEX_MAX_DEFAULT,
  parameter int LENGTH_WIDTH    = clt_pkg::LENGTH_WIDTH_DEFAULT,
  parameter int FIFO_DEPTH      = clt_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [clt_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_action,
  input  logic [7:0]                in_data_byte,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [1:0]                out_kind,
  output logic [7:0]                out_token_byte,
  output logic [5:0]                out_token_index,
  output logic                      out_is_trailing,
  output logic                      out_last
);
  import clt_pkg::*;

  logic    q_full, q_push, q_empty;
  record_t q_rec, q_head;
  qctl_t   q_ctl;
  result_t res;

  // Parser
  clt_front #(
    .TOKEN_INDEX_MAX (TOKEN_INDEX_MAX),
    .LENGTH_WIDTH    (LENGTH_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_action    (in_action),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_rec        (q_rec)
  );

  // Record queue
  clt_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_rec),
    .full     (q_full),
    .ctl_in   (q_ctl),
    .empty    (q_empty),
    .head_rec (q_head)
  );

  // Output stage
  clt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_ctl     (q_ctl),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  assign out_kind        = res.kind;
  assign out_token_byte  = res.token_byte;
  assign out_token_index = res.token_index;
  assign out_is_trailing = res.is_trailing;
  assign out_last        = res.last;

endmodule

### dv/crlf_line_command_tokenizer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crlf_line_command_tokenizer_checker
// Watches the input, result and configuration ports of the tokenizer. It
// keeps its own copy of the line parser state, works out the token results
// each accepted request must produce, and compares every popped result with
// the oldest outstanding one. Mismatches and the outstanding count go to
// the testbench top.
// ----------------------------------------------------------------------------
module crlf_line_command_tokenizer_checker #(
  parameter int TOKEN_INDEX_MAX = clt_pkg::TOKEN_INDEX_MAX_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [clt_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_push,
  input  logic                      in_full,
  input  logic                      in_action,
  input  logic [7:0]                in_data_byte,
  input  logic                      out_empty,
  input  logic                      out_pop,
  input  logic [1:0]                out_kind,
  input  logic [7:0]                out_token_byte,
  input  logic [5:0]                out_token_index,
  input  logic                      out_is_trailing,
  input  logic                      out_last,
  output int                        mismatch_count,
  output int                        tokens_outstanding
);
  import clt_pkg::*;

  localparam int REPORT_LIMIT = 10;

  localparam logic [1:0] BETWEEN_WORDS = 2'd0;
  localparam logic [1:0] IN_WORD       = 2'd1;
  localparam logic [1:0] IN_TRAILING   = 2'd2;

  // Parser state mirrored from the block
  logic [1:0]       line_mode;
  logic             prev_space;
  logic             cr_held;
  logic             name_found;
  logic             trail_has_data;
  logic [5:0]       token_num;
  logic [15:0]      line_len;
  logic             line_killed;
  logic [CFG_W-1:0] limit_reg;

  // Results of the request being parsed, then the queue of expected tokens
  result_t step_out [2];
  int      step_n;
  result_t expected_tokens [$];

  function automatic logic is_blank(logic [7:0] b);
    return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE;
  endfunction

  task automatic add_result(logic [1:0] kind, logic [7:0] tb, logic [5:0] idx, logic trail);
    result_t r;
    r.kind        = kind;
    r.token_byte  = tb;
    r.token_index = idx;
    r.is_trailing = trail;
    r.last        = 1'b0;
    step_out[step_n] = r;
    step_n++;
  endtask

  task automatic next_token();
    if (token_num < TOKEN_INDEX_MAX) token_num++;
  endtask

  task automatic clear_line();
    line_mode      = BETWEEN_WORDS;
    prev_space     = 1'b0;
    cr_held        = 1'b0;
    name_found     = 1'b0;
    trail_has_data = 1'b0;
    token_num      = '0;
    line_len       = '0;
  endtask

  // Trailing bytes only count once the line has a command name
  task automatic trailing_byte(logic [7:0] b);
    if (name_found) begin
      add_result(KIND_BYTE, b, token_num, 1'b1);
      trail_has_data = 1'b1;
    end
  endtask

  // Handle a byte that does not end the line
  task automatic word_byte(logic [7:0] b);
    if (line_mode == IN_TRAILING) begin
      if (b == CH_CR) cr_held = 1'b1;
      else trailing_byte(b);
    end else begin
      if (b == CH_CR) cr_held = 1'b1;
      if (is_blank(b)) begin
        if (line_mode == IN_WORD) begin
          add_result(KIND_END, 8'h00, token_num, 1'b0);
          next_token();
          line_mode = BETWEEN_WORDS;
        end
        prev_space = (b == CH_SPACE);
      end else if (line_mode == BETWEEN_WORDS && prev_space && b == CH_COLON) begin
        line_mode  = IN_TRAILING;
        prev_space = 1'b0;
      end else begin
        prev_space = 1'b0;
        line_mode  = IN_WORD;
        name_found = 1'b1;
        add_result(KIND_BYTE, b, token_num, 1'b0);
      end
    end
  endtask

  // Parse one accepted request and queue the results it causes
  task automatic tokenize_request(logic act, logic [7:0] b);
    logic [16:0] next_len;
    result_t     r;
    step_n = 0;
    if (act == ACT_RESTART) begin
      line_killed = 1'b0;
      clear_line();
    end else if (!line_killed) begin
      next_len = {1'b0, line_len} + 17'd1;
      if (next_len > {1'b0, limit_reg}) begin
        line_killed = 1'b1;
        add_result(KIND_TOO_LONG, 8'h00, 6'd0, 1'b0);
      end else begin
        line_len = next_len[16] ? 16'hFFFF : next_len[15:0];
        if (cr_held && b == CH_LF) begin
          if (name_found) begin
            if (line_mode == IN_TRAILING && trail_has_data) begin
              add_result(KIND_END, 8'h00, token_num, 1'b1);
              next_token();
            end
            add_result(KIND_COMPLETE, 8'h00, token_num, 1'b0);
          end
          clear_line();
        end else begin
          // A held CR that is not followed by LF belongs to the trailing text
          if (cr_held) begin
            cr_held = 1'b0;
            if (line_mode == IN_TRAILING) trailing_byte(CH_CR);
          end
          word_byte(b);
        end
      end
    end
    for (int i = 0; i < step_n; i++) begin
      r = step_out[i];
      r.last = (i == step_n - 1);
      expected_tokens = {expected_tokens, r};
    end
  endtask

  // Track config and requests, compare popped results
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (!rst_n) begin
      limit_reg   = MAX_LEN_RESET;
      line_killed = 1'b0;
      clear_line();
      expected_tokens.delete();
    end else begin
      // A request at the same edge as a write still sees the old limit
      if (in_push && !in_full) tokenize_request(in_action, in_data_byte);
      if (cfg_we) limit_reg = cfg_data;
      if (out_pop && !out_empty) begin
        seen.kind        = out_kind;
        seen.token_byte  = out_token_byte;
        seen.token_index = out_token_index;
        seen.is_trailing = out_is_trailing;
        seen.last        = out_last;
        if (expected_tokens.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result kind %0d byte %02h index %0d trailing %0b last %0b",
                     $time, seen.kind, seen.token_byte, seen.token_index,
                     seen.is_trailing, seen.last);
        end else begin
          want = expected_tokens.pop_front();
          if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $write("%0t: mismatch (expected/actual) kind %0d/%0d byte %02h/%02h",
                     $time, want.kind, seen.kind, want.token_byte, seen.token_byte);
              $display(" index %0d/%0d trailing %0b/%0b last %0b/%0b",
                       want.token_index, seen.token_index, want.is_trailing,
                       seen.is_trailing, want.last, seen.last);
            end
          end
        end
      end
    end
    tokens_outstanding = expected_tokens.size();
  end

endmodule

### dv/crlf_line_command_tokenizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crlf_line_command_tokenizer_tb
// Drives byte requests into the tokenizer: a directed set of framing corner
// cases and length limit cases, then random command lines, noise and
// restarts over four phases with different line limits and idle patterns,
// including a long result-side hold that fills the block. The checker
// beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module crlf_line_command_tokenizer_tb;
  import clt_pkg::*;

  localparam int          SETTLE_CYCLES = 16;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          PHASE_ITEMS   = 400;
  localparam longint      RUN_LIMIT_NS  = 10_000_000;
  localparam logic [7:0]  CH_VT         = 8'd11;
  localparam logic [7:0]  CH_FF         = 8'd12;
  localparam logic [15:0] LIMIT_ZERO    = 16'd0;
  localparam logic [15:0] LIMIT_ONE     = 16'd1;
  localparam logic [15:0] LIMIT_MAX     = 16'hFFFF;

  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             cfg_we          = 1'b0;
  logic [CFG_W-1:0] cfg_data        = '0;
  logic             in_push         = 1'b0;
  logic             in_full;
  logic             in_action       = ACT_DATA;
  logic [7:0]       in_data_byte    = 8'h00;
  logic             out_empty;
  logic             out_pop         = 1'b0;
  logic [1:0]       out_kind;
  logic [7:0]       out_token_byte;
  logic [5:0]       out_token_index;
  logic             out_is_trailing;
  logic             out_last;

  int               mismatch_count;
  int               tokens_outstanding;

  int               send_idle_pct   = 0;
  int               recv_stall_pct  = 0;
  logic             pressure_armed  = 1'b0;
  logic             rx_hold         = 1'b0;
  int               requests_sent   = 0;
  int               unframed_bytes  = 0;
  logic             line_overflow   = 1'b0;
  logic [15:0]      line_limit      = MAX_LEN_RESET;

  always #6 clk = ~clk;

  crlf_line_command_tokenizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_kind        (out_kind),
    .out_token_byte  (out_token_byte),
    .out_token_index (out_token_index),
    .out_is_trailing (out_is_trailing),
    .out_last        (out_last)
  );

  crlf_line_command_tokenizer_checker token_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_action          (in_action),
    .in_data_byte       (in_data_byte),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_kind           (out_kind),
    .out_token_byte     (out_token_byte),
    .out_token_index    (out_token_index),
    .out_is_trailing    (out_is_trailing),
    .out_last           (out_last),
    .mismatch_count     (mismatch_count),
    .tokens_outstanding (tokens_outstanding)
  );

  // Result side: random stalls, forced low during the hold
  initial begin
    forever begin
      @(negedge clk);
      out_pop <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long result-side hold, counted on rising edges
  initial begin
    wait (pressure_armed);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  // Offer one request, with random gaps before it, until it is taken
  task automatic send_byte(input logic act, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push      <= 1'b1;
    in_action    <= act;
    in_data_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    @(negedge clk);
    requests_sent++;
    if (act == ACT_RESTART) begin
      unframed_bytes = 0;
      line_overflow  = 1'b0;
    end else begin
      unframed_bytes++;
      if (unframed_bytes > line_limit) line_overflow = 1'b1;
    end
  endtask

  task automatic push_char(input logic [7:0] b);
    send_byte(ACT_DATA, b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  // Drop the request, wait for all results and let the pipeline empty
  task automatic settle();
    in_push <= 1'b0;
    while (tokens_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    line_limit = v;
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [7:0] word_char();
    if ($urandom_range(7) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(7))
      0: return CH_TAB;
      1: return CH_VT;
      2: return CH_FF;
      3: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] trail_char();
    case ($urandom_range(7))
      0: return CH_SPACE;
      1: return CH_COLON;
      2: return CH_CR;
      3: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  // Well-formed line: name, parameters, optional trailing text, CR LF
  task automatic send_command_line();
    int n_params;
    int n_chars;
    if ($urandom_range(7) == 0) push_char(blank_char());
    n_chars = $urandom_range(1, 6);
    repeat (n_chars) push_char(word_char());
    n_params = ($urandom_range(39) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 4);
    repeat (n_params) begin
      push_char(blank_char());
      if ($urandom_range(3) == 0) push_char(blank_char());
      n_chars = $urandom_range(1, 5);
      repeat (n_chars) push_char(word_char());
    end
    if ($urandom_range(1) == 1) begin
      push_char(CH_SPACE);
      push_char(CH_COLON);
      n_chars = $urandom_range(0, 8);
      repeat (n_chars) push_char(trail_char());
    end
    push_char(CH_CR);
    push_char(CH_LF);
    unframed_bytes = 0;
  endtask

  // Broken input: random bytes biased toward the framing characters
  task automatic send_noise();
    int n_bytes;
    n_bytes = $urandom_range(1, 12);
    repeat (n_bytes) begin
      case ($urandom_range(7))
        0: push_char(CH_CR);
        1: push_char(CH_LF);
        2: push_char(CH_SPACE);
        3: push_char(CH_COLON);
        default: push_char(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic run_phase(input int idle, input int stall, input logic [15:0] limit,
                           input logic squeeze);
    int stop_at;
    int pick;
    settle();
    write_limit(limit);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    if (squeeze) pressure_armed = 1'b1;
    stop_at = requests_sent + PHASE_ITEMS;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(99);
      if (line_overflow || pick < 4) send_byte(ACT_RESTART, 8'($urandom_range(0, 255)));
      else if (pick < 84) send_command_line();
      else send_noise();
    end
  endtask

  initial begin
    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Name with the extreme byte values, trailing text with a held-back CR
    push_char(8'h00);
    push_char(8'hFF);
    send_text(" p :a\015b\015\012");
    // Trailing text before any name produces nothing
    send_text(" :z\015\012");
    // CR inside a word splits it; an empty trailing parameter is dropped
    send_text("W\015X :\015\012");
    // Restart in the middle of a line
    push_char("R");
    send_byte(ACT_RESTART, 8'hA5);

    // Zero limit: the first byte overflows, later bytes are ignored
    settle();
    write_limit(LIMIT_ZERO);
    push_char("a");
    push_char("b");
    send_byte(ACT_RESTART, 8'h00);
    // Limit of one: the second byte overflows
    settle();
    write_limit(LIMIT_ONE);
    push_char("a");
    push_char(CH_CR);
    send_byte(ACT_RESTART, 8'hFF);

    run_phase(0, 0, LIMIT_MAX, 1'b1);
    run_phase(81, 0, 16'($urandom_range(8, 48)), 1'b0);
    run_phase(0, 81, MAX_LEN_RESET, 1'b0);
    run_phase(13, 13, 16'($urandom_range(49, 400)), 1'b0);
    settle();

    if (mismatch_count == 0 && tokens_outstanding == 0) begin
      $display("crlf_line_command_tokenizer_tb: PASS");
    end else begin
      $display("crlf_line_command_tokenizer_tb: FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(RUN_LIMIT_NS);
    $display("crlf_line_command_tokenizer_tb: FAIL");
    $finish;
  end

endmodule
